// ===== rtl/msi_pkg.sv =====
// msi_pkg: types and fixed constants of the mass-spring integrator
// used by mass_spring_integrator_core and its checker; no dependencies
`default_nettype none

package msi_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int MAX_SPRINGS = 128;
  localparam int FRAC_BITS   = 16;
  localparam int PT_AW       = 6;
  localparam int SP_AW       = 7;
  localparam int CFG_AW      = 5;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_ADD_PT = 3'd1;
  localparam logic [2:0] OP_ADD_SP = 3'd2;
  localparam logic [2:0] OP_STEP   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_INVM  = 3'd1;
  localparam logic [2:0] REG_STIFF = 3'd2;
  localparam logic [2:0] REG_DAMP  = 3'd3;
  localparam logic [2:0] REG_REST  = 3'd4;
  localparam logic [2:0] REG_EXT_X = 3'd5;
  localparam logic [2:0] REG_EXT_Y = 3'd6;
  localparam logic [2:0] REG_EXT_Z = 3'd7;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_pos_z;
    logic signed [31:0] in_vel_x;
    logic signed [31:0] in_vel_y;
    logic signed [31:0] in_vel_z;
    logic               in_fixed;
    logic [5:0]         end_a;
    logic [5:0]         end_b;
    logic [16:0]        time_step;
    logic [5:0]         point_index;
  } msi_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic [1:0]         status;
    logic [6:0]         points_held;
    logic [7:0]         springs_held;
  } msi_out_t;

endpackage

`default_nettype wire

// ===== rtl/mass_spring_integrator_core.sv =====
// mass_spring_integrator_core: point and spring tables with a step sequencer
// built around one shared multiplier, a bit-serial divider and square root
// depends on msi_pkg
`default_nettype none

// One item at a time; busy is high from acceptance until the result strobe.
// Clear, add-point, add-spring and unused operations give their result from
// the execute state, an in-range read from the read state after it. A step
// loads each force with the external force, runs the springs, then advances
// the free points; a zero-length spring is dropped after its square root and
// a fixed point is not moved. The midpoint method runs it all twice. Each
// spring of nonzero length uses the bit-serial divider four times. The result
// strobe lasts one cycle and cannot be held off. No clearing pass after reset.
module mass_spring_integrator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  msi_pkg::msi_in_t             in_item,
  output logic                         out_valid,
  output msi_pkg::msi_out_t            out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msi_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_EXEC  = 5'd1;
  localparam logic [4:0] S_READ  = 5'd2;
  localparam logic [4:0] S_FINIT = 5'd3;
  localparam logic [4:0] S_SPR   = 5'd4;
  localparam logic [4:0] S_ENDS  = 5'd5;
  localparam logic [4:0] S_RDA   = 5'd6;
  localparam logic [4:0] S_RDB   = 5'd7;
  localparam logic [4:0] S_SQ    = 5'd8;
  localparam logic [4:0] S_SQRT  = 5'd9;
  localparam logic [4:0] S_STIF  = 5'd10;
  localparam logic [4:0] S_DOT   = 5'd11;
  localparam logic [4:0] S_DIV   = 5'd12;
  localparam logic [4:0] S_DAMP  = 5'd13;
  localparam logic [4:0] S_CMUL  = 5'd14;
  localparam logic [4:0] S_FRA   = 5'd15;
  localparam logic [4:0] S_FRA_W = 5'd16;
  localparam logic [4:0] S_FRB_W = 5'd17;
  localparam logic [4:0] S_ADV   = 5'd18;
  localparam logic [4:0] S_ADV_R = 5'd19;
  localparam logic [4:0] S_ADV_M = 5'd20;

  localparam logic [30:0] INVM_RST  = 31'd6554;
  localparam logic [30:0] STIFF_RST = 31'd2621440;
  localparam logic [30:0] REST_RST  = 31'd65536;

  localparam int PA = msi_pkg::PT_AW;
  localparam int SA = msi_pkg::SP_AW;
  localparam int FB = msi_pkg::FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return $signed(v[31:0]);
  endfunction

  function automatic logic signed [63:0] qtr(input logic signed [63:0] v,
                                             input logic half);
    logic signed [63:0] bias;
    logic signed [63:0] adj;
    bias = half ? ((64'sd1 <<< (FB + 1)) - 64'sd1) : ((64'sd1 <<< FB) - 64'sd1);
    adj  = v + (v[63] ? bias : 64'sd0);
    return half ? (adj >>> (FB + 1)) : (adj >>> FB);
  endfunction

  function automatic logic signed [31:0] add_sat(input logic [31:0] a,
                                                 input logic [31:0] b);
    return sat32({{32{a[31]}}, a} + {{32{b[31]}}, b});
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic [31:0] a,
                                                 input logic [31:0] b);
    return sat32({{32{a[31]}}, a} - {{32{b[31]}}, b});
  endfunction

  // control and configuration
  logic [4:0]          state_r;
  logic                out_valid_r;
  msi_pkg::msi_out_t   out_r;
  msi_pkg::msi_in_t    item_r;
  logic [6:0]          pcnt_r;
  logic [7:0]          scnt_r;
  logic                mode_r;
  logic [30:0]         invm_r, stiff_r, damp_r, rest_r;
  logic [31:0]         extx_r, exty_r, extz_r;
  logic                phase_r;
  logic [6:0]          pt_r;
  logic [7:0]          spr_r;
  logic [3:0]          k_r;
  logic [1:0]          c_r;

  // datapath
  logic [PA-1:0]       a_r, b_r;
  msi_pkg::vec3_t      pa_r, va_r;
  logic signed [31:0]  d_r [3];
  logic signed [31:0]  dv_r [3];
  logic [63:0]         sq_r, n_r, root_r, bit_r;
  logic [31:0]         len_r;
  logic signed [31:0]  smag_r, rel_r, mag_r;
  logic signed [63:0]  dot_r;
  logic [63:0]         div_mag_r;
  logic [31:0]         div_rem_r;
  logic [5:0]          div_cnt_r;
  logic                div_neg_r, div_rel_r;
  logic signed [31:0]  comp_r [3];
  logic signed [31:0]  acc_r [3];
  logic signed [31:0]  np_r [3];
  logic signed [31:0]  nv_r [2];

  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod_r;

  // memories
  msi_pkg::vec3_t      pos_mem [msi_pkg::MAX_POINTS];
  msi_pkg::vec3_t      vel_mem [msi_pkg::MAX_POINTS];
  msi_pkg::vec3_t      frc_mem [msi_pkg::MAX_POINTS];
  msi_pkg::vec3_t      svp_mem [msi_pkg::MAX_POINTS];
  msi_pkg::vec3_t      svv_mem [msi_pkg::MAX_POINTS];
  logic                fix_mem [msi_pkg::MAX_POINTS];
  logic [2*PA-1:0]     spr_mem [msi_pkg::MAX_SPRINGS];

  msi_pkg::vec3_t      pos_rd, vel_rd, frc_rd, svp_rd, svv_rd;
  logic                fix_rd;
  logic [2*PA-1:0]     spr_rd;

  logic [PA-1:0]       rd_addr, pv_waddr, frc_waddr;
  logic                pv_we, fix_we, sv_we, frc_we, spr_we;
  msi_pkg::vec3_t      pos_wd, vel_wd, frc_wd;

  logic                cfg_wr;
  logic                half, use_saved;
  msi_pkg::vec3_t      base_p, base_v;
  logic signed [31:0]  hq;
  logic signed [31:0]  h_s, invm_s;
  logic signed [33:0]  lr_wide;
  logic signed [31:0]  lrest;
  logic [63:0]         sq_t, root_nxt;
  logic                sq_ge;
  logic [32:0]         rem_sh;
  logic                qbit;
  logic [63:0]         quo;
  logic signed [63:0]  quo_s;
  logic signed [31:0]  div_res;
  logic [1:0]          ln, rl;
  logic signed [31:0]  dot_sat;
  logic signed [63:0]  dot_num;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      msi_pkg::REG_MODE:  prdata = {31'd0, mode_r};
      msi_pkg::REG_INVM:  prdata = {1'b0, invm_r};
      msi_pkg::REG_STIFF: prdata = {1'b0, stiff_r};
      msi_pkg::REG_DAMP:  prdata = {1'b0, damp_r};
      msi_pkg::REG_REST:  prdata = {1'b0, rest_r};
      msi_pkg::REG_EXT_X: prdata = extx_r;
      msi_pkg::REG_EXT_Y: prdata = exty_r;
      msi_pkg::REG_EXT_Z: prdata = extz_r;
      default:            prdata = '0;
    endcase
  end

  assign half      = mode_r & ~phase_r;
  assign use_saved = phase_r;
  assign base_p    = use_saved ? svp_rd : pos_rd;
  assign base_v    = use_saved ? svv_rd : vel_rd;
  assign hq        = sat32(qtr(prod_r, half));
  assign h_s       = $signed({15'd0, item_r.time_step});
  assign invm_s    = $signed({1'b0, invm_r});
  assign lr_wide   = $signed({2'b00, len_r}) - $signed({3'b000, rest_r});
  assign lrest     = sat32({{30{lr_wide[33]}}, lr_wide});
  assign dot_sat   = sat32(dot_r);
  assign dot_num   = {{16{dot_sat[31]}}, dot_sat, {FB{1'b0}}};

  // square root step
  assign sq_t     = root_r + bit_r;
  assign sq_ge    = (n_r >= sq_t);
  assign root_nxt = sq_ge ? ((root_r >> 1) + bit_r) : (root_r >> 1);

  // divider step
  assign rem_sh  = {div_rem_r, div_mag_r[63]};
  assign qbit    = (rem_sh >= {1'b0, len_r});
  assign quo     = {div_mag_r[62:0], qbit};
  assign quo_s   = div_neg_r ? -$signed(quo) : $signed(quo);
  assign div_res = sat32(quo_s);

  // lane of the operand issued (ln) and of the product returning (rl)
  always_comb begin
    ln = 2'd0;
    rl = 2'd0;
    unique case (k_r)
      4'd0, 4'd3, 4'd6: begin ln = 2'd0; rl = 2'd2; end
      4'd1, 4'd4, 4'd7: begin ln = 2'd1; rl = 2'd0; end
      4'd2, 4'd5, 4'd8: begin ln = 2'd2; rl = 2'd1; end
      4'd9:             begin ln = 2'd2; rl = 2'd2; end
      default:          begin ln = 2'd0; rl = 2'd0; end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: if (k_r < 4'd3) begin
        mul_a = d_r[ln];
        mul_b = d_r[ln];
      end
      S_DOT: if (k_r < 4'd3) begin
        mul_a = d_r[ln];
        mul_b = dv_r[ln];
      end
      S_STIF: begin
        mul_a = $signed({1'b0, stiff_r});
        mul_b = lrest;
      end
      S_DAMP: begin
        mul_a = $signed({1'b0, damp_r});
        mul_b = rel_r;
      end
      S_CMUL: begin
        mul_a = mag_r;
        mul_b = d_r[c_r];
      end
      S_ADV_M: begin
        if (k_r < 4'd3) begin
          mul_a = $signed(frc_rd[ln]);
          mul_b = invm_s;
        end else if (k_r < 4'd6) begin
          mul_a = h_s;
          mul_b = $signed(vel_rd[ln]);
        end else if (k_r < 4'd9) begin
          mul_a = h_s;
          mul_b = acc_r[ln];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // memory ports
  always_comb begin
    rd_addr   = pt_r[PA-1:0];
    pv_waddr  = pt_r[PA-1:0];
    frc_waddr = pt_r[PA-1:0];
    pv_we     = 1'b0;
    fix_we    = 1'b0;
    sv_we     = 1'b0;
    frc_we    = 1'b0;
    spr_we    = 1'b0;
    pos_wd    = np_r[2] == np_r[2] ? {np_r[2], np_r[1], np_r[0]} : '0;
    vel_wd    = {add_sat(base_v[2], hq), nv_r[1], nv_r[0]};
    frc_wd    = {extz_r, exty_r, extx_r};
    unique case (state_r)
      S_EXEC: begin
        rd_addr  = item_r.point_index;
        pv_waddr = pcnt_r[PA-1:0];
        pos_wd   = {item_r.in_pos_z, item_r.in_pos_y, item_r.in_pos_x};
        vel_wd   = {item_r.in_vel_z, item_r.in_vel_y, item_r.in_vel_x};
        if (item_r.operation == msi_pkg::OP_ADD_PT &&
            pcnt_r < 7'(msi_pkg::MAX_POINTS)) begin
          pv_we  = 1'b1;
          fix_we = 1'b1;
        end
        if (item_r.operation == msi_pkg::OP_ADD_SP &&
            scnt_r < 8'(msi_pkg::MAX_SPRINGS) &&
            {1'b0, item_r.end_a} < pcnt_r && {1'b0, item_r.end_b} < pcnt_r) begin
          spr_we = 1'b1;
        end
      end
      S_FINIT: frc_we = (pt_r != pcnt_r);
      S_ENDS:  rd_addr = spr_rd[PA-1:0];
      S_RDA:   rd_addr = b_r;
      S_FRA:   rd_addr = a_r;
      S_FRA_W: begin
        rd_addr   = b_r;
        frc_we    = 1'b1;
        frc_waddr = a_r;
        frc_wd    = {add_sat(frc_rd[2], comp_r[2]), add_sat(frc_rd[1], comp_r[1]),
                     add_sat(frc_rd[0], comp_r[0])};
      end
      S_FRB_W: begin
        frc_we    = 1'b1;
        frc_waddr = b_r;
        frc_wd    = {sub_sat(frc_rd[2], comp_r[2]), sub_sat(frc_rd[1], comp_r[1]),
                     sub_sat(frc_rd[0], comp_r[0])};
      end
      S_ADV_M: begin
        pv_we = (k_r == 4'd9);
        sv_we = (k_r == 4'd9) && half;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      pos_mem[pv_waddr] <= pos_wd;
      vel_mem[pv_waddr] <= vel_wd;
    end
    pos_rd <= pos_mem[rd_addr];
    vel_rd <= vel_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sv_we) begin
      svp_mem[pv_waddr] <= pos_rd;
      svv_mem[pv_waddr] <= vel_rd;
    end
    svp_rd <= svp_mem[rd_addr];
    svv_rd <= svv_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (frc_we) frc_mem[frc_waddr] <= frc_wd;
    frc_rd <= frc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fix_we) fix_mem[pv_waddr] <= item_r.in_fixed;
    fix_rd <= fix_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (spr_we) spr_mem[scnt_r[SA-1:0]] <= {item_r.end_b, item_r.end_a};
    spr_rd <= spr_mem[spr_r[SA-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pcnt_r      <= '0;
      scnt_r      <= '0;
      mode_r      <= 1'b0;
      invm_r      <= INVM_RST;
      stiff_r     <= STIFF_RST;
      damp_r      <= '0;
      rest_r      <= REST_RST;
      extx_r      <= '0;
      exty_r      <= '0;
      extz_r      <= '0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          msi_pkg::REG_MODE:  mode_r  <= pwdata[0];
          msi_pkg::REG_INVM:  invm_r  <= pwdata[30:0];
          msi_pkg::REG_STIFF: stiff_r <= pwdata[30:0];
          msi_pkg::REG_DAMP:  damp_r  <= pwdata[30:0];
          msi_pkg::REG_REST:  rest_r  <= pwdata[30:0];
          msi_pkg::REG_EXT_X: extx_r  <= pwdata;
          msi_pkg::REG_EXT_Y: exty_r  <= pwdata;
          msi_pkg::REG_EXT_Z: extz_r  <= pwdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (start) begin
          item_r  <= in_item;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          out_r              <= '0;
          out_r.points_held  <= pcnt_r;
          out_r.springs_held <= scnt_r;
          state_r            <= S_IDLE;
          unique case (item_r.operation)
            msi_pkg::OP_CLEAR: begin
              pcnt_r             <= '0;
              scnt_r             <= '0;
              out_r.points_held  <= '0;
              out_r.springs_held <= '0;
              out_valid_r        <= 1'b1;
            end
            msi_pkg::OP_ADD_PT: begin
              if (pcnt_r >= 7'(msi_pkg::MAX_POINTS)) begin
                out_r.status <= msi_pkg::ST_FULL;
              end else begin
                pcnt_r            <= pcnt_r + 7'd1;
                out_r.points_held <= pcnt_r + 7'd1;
              end
              out_valid_r <= 1'b1;
            end
            msi_pkg::OP_ADD_SP: begin
              if (scnt_r >= 8'(msi_pkg::MAX_SPRINGS)) begin
                out_r.status <= msi_pkg::ST_FULL;
              end else if ({1'b0, item_r.end_a} >= pcnt_r ||
                           {1'b0, item_r.end_b} >= pcnt_r) begin
                out_r.status <= msi_pkg::ST_RANGE;
              end else begin
                scnt_r             <= scnt_r + 8'd1;
                out_r.springs_held <= scnt_r + 8'd1;
              end
              out_valid_r <= 1'b1;
            end
            msi_pkg::OP_STEP: begin
              phase_r <= 1'b0;
              pt_r    <= '0;
              state_r <= S_FINIT;
            end
            msi_pkg::OP_READ: begin
              if ({1'b0, item_r.point_index} >= pcnt_r) begin
                out_r.status <= msi_pkg::ST_RANGE;
                out_valid_r  <= 1'b1;
              end else begin
                state_r <= S_READ;
              end
            end
            default: out_valid_r <= 1'b1;
          endcase
        end
        S_READ: begin
          out_r.out_pos_x <= $signed(pos_rd[0]);
          out_r.out_pos_y <= $signed(pos_rd[1]);
          out_r.out_pos_z <= $signed(pos_rd[2]);
          out_r.out_vel_x <= $signed(vel_rd[0]);
          out_r.out_vel_y <= $signed(vel_rd[1]);
          out_r.out_vel_z <= $signed(vel_rd[2]);
          out_valid_r     <= 1'b1;
          state_r         <= S_IDLE;
        end
        S_FINIT: begin
          if (pt_r == pcnt_r) begin
            spr_r   <= '0;
            state_r <= S_SPR;
          end else begin
            pt_r <= pt_r + 7'd1;
          end
        end
        S_SPR: begin
          if (spr_r == scnt_r) begin
            pt_r    <= '0;
            state_r <= S_ADV;
          end else begin
            state_r <= S_ENDS;
          end
        end
        S_ENDS: begin
          a_r     <= spr_rd[PA-1:0];
          b_r     <= spr_rd[2*PA-1:PA];
          state_r <= S_RDA;
        end
        S_RDA: begin
          pa_r    <= pos_rd;
          va_r    <= vel_rd;
          state_r <= S_RDB;
        end
        S_RDB: begin
          for (int c = 0; c < 3; c++) begin
            d_r[c]  <= sub_sat(pos_rd[c], pa_r[c]);
            dv_r[c] <= sub_sat(vel_rd[c], va_r[c]);
          end
          k_r     <= '0;
          sq_r    <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (k_r != 4'd0) sq_r <= sq_r + prod_r;
          if (k_r == 4'd3) begin
            n_r     <= sq_r + prod_r;
            root_r  <= '0;
            bit_r   <= 64'd1 << 62;
            state_r <= S_SQRT;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_SQRT: begin
          if (sq_ge) n_r <= n_r - sq_t;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          if (bit_r[0]) begin
            if (root_nxt[31:0] == 32'd0) begin
              spr_r   <= spr_r + 8'd1;
              state_r <= S_SPR;
            end else begin
              len_r   <= root_nxt[31:0];
              k_r     <= '0;
              state_r <= S_STIF;
            end
          end
        end
        S_STIF: begin
          if (k_r == 4'd1) begin
            smag_r  <= sat32(qtr(prod_r, 1'b0));
            k_r     <= '0;
            dot_r   <= '0;
            state_r <= S_DOT;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_DOT: begin
          if (k_r != 4'd0 && k_r != 4'd4) dot_r <= dot_r + qtr(prod_r, 1'b0);
          if (k_r == 4'd4) begin
            div_mag_r <= dot_num[63] ? 64'(-dot_num) : 64'(dot_num);
            div_neg_r <= dot_num[63];
            div_rem_r <= '0;
            div_cnt_r <= '0;
            div_rel_r <= 1'b1;
            state_r   <= S_DIV;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_DIV: begin
          div_mag_r <= quo;
          div_rem_r <= qbit ? 32'(rem_sh - {1'b0, len_r}) : rem_sh[31:0];
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd63) begin
            k_r <= '0;
            if (div_rel_r) begin
              rel_r   <= div_res;
              state_r <= S_DAMP;
            end else begin
              comp_r[c_r] <= div_res;
              if (c_r == 2'd2) begin
                state_r <= S_FRA;
              end else begin
                c_r     <= c_r + 2'd1;
                state_r <= S_CMUL;
              end
            end
          end
        end
        S_DAMP: begin
          if (k_r == 4'd1) begin
            mag_r   <= add_sat(smag_r, sat32(qtr(prod_r, 1'b0)));
            c_r     <= '0;
            k_r     <= '0;
            state_r <= S_CMUL;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_CMUL: begin
          if (k_r == 4'd1) begin
            div_mag_r <= prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
            div_neg_r <= prod_r[63];
            div_rem_r <= '0;
            div_cnt_r <= '0;
            div_rel_r <= 1'b0;
            state_r   <= S_DIV;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_FRA:   state_r <= S_FRA_W;
        S_FRA_W: state_r <= S_FRB_W;
        S_FRB_W: begin
          spr_r   <= spr_r + 8'd1;
          state_r <= S_SPR;
        end
        S_ADV: begin
          if (pt_r == pcnt_r) begin
            if (mode_r && !phase_r) begin
              phase_r <= 1'b1;
              pt_r    <= '0;
              state_r <= S_FINIT;
            end else begin
              out_r              <= '0;
              out_r.status       <= msi_pkg::ST_OK;
              out_r.points_held  <= pcnt_r;
              out_r.springs_held <= scnt_r;
              out_valid_r        <= 1'b1;
              state_r            <= S_IDLE;
            end
          end else begin
            state_r <= S_ADV_R;
          end
        end
        S_ADV_R: begin
          k_r <= '0;
          if (fix_rd) begin
            pt_r    <= pt_r + 7'd1;
            state_r <= S_ADV;
          end else begin
            state_r <= S_ADV_M;
          end
        end
        S_ADV_M: begin
          if (k_r >= 4'd1 && k_r <= 4'd3) acc_r[rl] <= sat32(qtr(prod_r, 1'b0));
          if (k_r >= 4'd4 && k_r <= 4'd6) np_r[rl] <= add_sat(base_p[rl], hq);
          if (k_r == 4'd7 || k_r == 4'd8) nv_r[rl[0]] <= add_sat(base_v[rl], hq);
          if (k_r == 4'd9) begin
            pt_r    <= pt_r + 7'd1;
            state_r <= S_ADV;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msi_checker.sv =====
// msi_checker: port-level assertions for mass_spring_integrator_core
// bound to the top level below; depends on msi_pkg
`default_nettype none

module msi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input msi_pkg::msi_out_t out_item
);

  // one result beat per item, never back to back
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after an accepted item");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while a result beat is shown");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.points_held <= 7'd64 && out_item.springs_held <= 8'd128 &&
                   out_item.status != 2'd3))
    else $error("result counts or status out of range");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != msi_pkg::ST_OK) |->
      (out_item.out_pos_x == 32'sd0 && out_item.out_vel_z == 32'sd0))
    else $error("nonzero data with an error status");

endmodule

bind mass_spring_integrator_core msi_checker u_msi_checker (.*);

`default_nettype wire
